// File: hdl/gscr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gscr_pkg
// Shared codes and the status word layout for the GPU status/control block.
// ----------------------------------------------------------------------------
package gscr_pkg;

    // Bus access kinds carried on cmd
    typedef enum logic [1:0] {
        CMD_WRITE_GP0   = 2'd0,
        CMD_WRITE_GP1   = 2'd1,
        CMD_READ_STATUS = 2'd2,
        CMD_READ_LATCH  = 2'd3
    } cmd_t;

    // Command-port opcodes
    localparam logic [7:0] GP0_IRQ_REQUEST  = 8'h1F;
    localparam logic [7:0] GP0_DRAW_MODE    = 8'hE1;
    localparam logic [7:0] GP0_AREA_TL      = 8'hE3;
    localparam logic [7:0] GP0_AREA_BR      = 8'hE4;
    localparam logic [7:0] GP0_DRAW_OFFSET  = 8'hE5;
    localparam logic [7:0] GP0_MASK_BITS    = 8'hE6;

    // Control-port opcodes
    localparam logic [7:0] GP1_RESET        = 8'h00;
    localparam logic [7:0] GP1_IRQ_ACK      = 8'h02;
    localparam logic [7:0] GP1_DISP_ENABLE  = 8'h03;
    localparam logic [7:0] GP1_DMA_DIR      = 8'h04;
    localparam logic [7:0] GP1_DISP_START   = 8'h05;
    localparam logic [7:0] GP1_HRANGE       = 8'h06;
    localparam logic [7:0] GP1_VRANGE       = 8'h07;
    localparam logic [7:0] GP1_DISP_MODE    = 8'h08;
    localparam logic [3:0] GP1_READBACK_HI  = 4'h1;

    // Read-back selectors
    localparam logic [3:0] RB_AREA_TL       = 4'd3;
    localparam logic [3:0] RB_AREA_BR       = 4'd4;
    localparam logic [3:0] RB_DRAW_OFFSET   = 4'd5;
    localparam logic [3:0] RB_VERSION       = 4'd7;
    localparam logic [3:0] RB_ZERO          = 4'd8;

    localparam logic [31:0] GPU_VERSION     = 32'd2;

    // Pack the kept fields into the status word
    function automatic logic [31:0] pack_status(
        input logic [13:0] draw_mode,
        input logic [1:0]  mask,
        input logic        field,
        input logic [6:0]  disp_mode,
        input logic        disp_off,
        input logic        irq,
        input logic [1:0]  dma_dir
    );
        logic [31:0] s;
        s          = '0;
        s[10:0]    = draw_mode[10:0];
        s[12:11]   = mask;
        s[13]      = field;
        s[16]      = disp_mode[6];
        s[18:17]   = disp_mode[1:0];
        s[22:19]   = disp_mode[5:2];
        s[23]      = disp_off;
        s[24]      = irq;
        s[28:26]   = 3'b111;
        s[30:29]   = dma_dir;
        return s;
    endfunction

endpackage

// File: hdl/gpu_status_control_registers_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpu_status_control_registers_unit
// Command/control port decode, kept GPU state and status word packing.
// ----------------------------------------------------------------------------
// One bus access is taken per cycle unless the input is held off. An access
// waits in an input register, where a write updates the kept state and a
// read packs the status word or picks the read-back latch into the result
// register; a read result passes the input register and then the result
// register, and writes give no result. Input is taken every cycle while the
// result register is empty or being drained, so the sustained rate is one
// access per cycle; only a stalled result with a read behind holds input off.
module gpu_status_control_registers_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data
);

    // Input register
    logic        stg_valid_reg;
    logic [1:0]  stg_cmd_reg;
    logic [31:0] stg_data_reg;

    // Kept state
    logic [13:0] draw_mode_bits_reg,   draw_mode_bits_next;
    logic [1:0]  mask_bits_reg,        mask_bits_next;
    logic [6:0]  display_mode_bits_reg, display_mode_bits_next;
    logic        display_disabled_reg, display_disabled_next;
    logic        interlace_field_reg,  interlace_field_next;
    logic        irq_flag_reg,         irq_flag_next;
    logic [1:0]  dma_direction_reg,    dma_direction_next;
    logic [19:0] area_top_left_reg,    area_top_left_next;
    logic [19:0] area_bottom_right_reg, area_bottom_right_next;
    logic [21:0] drawing_offset_reg,   drawing_offset_next;
    logic [18:0] display_start_reg,    display_start_next;
    logic [23:0] horizontal_range_reg, horizontal_range_next;
    logic [19:0] vertical_range_reg,   vertical_range_next;
    logic [31:0] readback_latch_reg,   readback_latch_next;

    // Result register
    logic        out_valid_reg;
    logic [31:0] read_data_reg, read_data_next;

    logic        stg_is_read;
    logic        stg_advance;
    logic [7:0]  op;

    assign stg_is_read = (stg_cmd_reg == gscr_pkg::CMD_READ_STATUS) ||
                         (stg_cmd_reg == gscr_pkg::CMD_READ_LATCH);
    assign stg_advance = stg_valid_reg && (!stg_is_read || !out_valid_reg || out_ready);
    assign in_ready    = !stg_valid_reg || stg_advance;
    assign op          = stg_data_reg[31:24];

    assign out_valid   = out_valid_reg;
    assign read_data   = read_data_reg;

    // Hold the accepted access
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stg_cmd_reg  <= cmd;
            stg_data_reg <= write_data;
        end
    end

    // Decode port writes and form the read result
    always_comb
    begin
        draw_mode_bits_next    = draw_mode_bits_reg;
        mask_bits_next         = mask_bits_reg;
        display_mode_bits_next = display_mode_bits_reg;
        display_disabled_next  = display_disabled_reg;
        interlace_field_next   = interlace_field_reg;
        irq_flag_next          = irq_flag_reg;
        dma_direction_next     = dma_direction_reg;
        area_top_left_next     = area_top_left_reg;
        area_bottom_right_next = area_bottom_right_reg;
        drawing_offset_next    = drawing_offset_reg;
        display_start_next     = display_start_reg;
        horizontal_range_next  = horizontal_range_reg;
        vertical_range_next    = vertical_range_reg;
        readback_latch_next    = readback_latch_reg;
        read_data_next         = readback_latch_reg;

        case (stg_cmd_reg)
            gscr_pkg::CMD_WRITE_GP0:
            begin
                case (op)
                    gscr_pkg::GP0_IRQ_REQUEST: irq_flag_next       = 1'b1;
                    gscr_pkg::GP0_DRAW_MODE:   draw_mode_bits_next = stg_data_reg[13:0];
                    gscr_pkg::GP0_AREA_TL:     area_top_left_next  = stg_data_reg[19:0];
                    gscr_pkg::GP0_AREA_BR:     area_bottom_right_next = stg_data_reg[19:0];
                    gscr_pkg::GP0_DRAW_OFFSET: drawing_offset_next = stg_data_reg[21:0];
                    gscr_pkg::GP0_MASK_BITS:   mask_bits_next      = stg_data_reg[1:0];
                    default: ;
                endcase
            end
            gscr_pkg::CMD_WRITE_GP1:
            begin
                if (op[7:4] == gscr_pkg::GP1_READBACK_HI)
                begin
                    case (stg_data_reg[3:0])
                        gscr_pkg::RB_AREA_TL:
                            readback_latch_next = {12'd0, area_top_left_reg};
                        gscr_pkg::RB_AREA_BR:
                            readback_latch_next = {12'd0, area_bottom_right_reg};
                        gscr_pkg::RB_DRAW_OFFSET:
                            readback_latch_next = {10'd0, drawing_offset_reg};
                        gscr_pkg::RB_VERSION:
                            readback_latch_next = gscr_pkg::GPU_VERSION;
                        gscr_pkg::RB_ZERO:
                            readback_latch_next = '0;
                        default: ;
                    endcase
                end
                else
                begin
                    case (op)
                        gscr_pkg::GP1_RESET:
                        begin
                            draw_mode_bits_next    = '0;
                            mask_bits_next         = '0;
                            display_mode_bits_next = '0;
                            display_disabled_next  = 1'b1;
                            interlace_field_next   = 1'b1;
                            irq_flag_next          = 1'b0;
                            dma_direction_next     = '0;
                            area_top_left_next     = '0;
                            area_bottom_right_next = '0;
                            drawing_offset_next    = '0;
                            display_start_next     = '0;
                            horizontal_range_next  = '0;
                            vertical_range_next    = '0;
                            readback_latch_next    = '0;
                        end
                        gscr_pkg::GP1_IRQ_ACK:     irq_flag_next         = 1'b0;
                        gscr_pkg::GP1_DISP_ENABLE: display_disabled_next = stg_data_reg[0];
                        gscr_pkg::GP1_DMA_DIR:     dma_direction_next    = stg_data_reg[1:0];
                        gscr_pkg::GP1_DISP_START:  display_start_next    = stg_data_reg[18:0];
                        gscr_pkg::GP1_HRANGE:      horizontal_range_next = stg_data_reg[23:0];
                        gscr_pkg::GP1_VRANGE:      vertical_range_next   = stg_data_reg[19:0];
                        gscr_pkg::GP1_DISP_MODE:   display_mode_bits_next = stg_data_reg[6:0];
                        default: ;
                    endcase
                end
            end
            gscr_pkg::CMD_READ_STATUS:
            begin
                read_data_next = gscr_pkg::pack_status(draw_mode_bits_reg, mask_bits_reg,
                    interlace_field_reg, display_mode_bits_reg, display_disabled_reg,
                    irq_flag_reg, dma_direction_reg);
            end
            default: ;
        endcase
    end

    // Advance the kept state when the staged access completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_mode_bits_reg    <= '0;
            mask_bits_reg         <= '0;
            display_mode_bits_reg <= '0;
            display_disabled_reg  <= 1'b1;
            interlace_field_reg   <= 1'b1;
            irq_flag_reg          <= 1'b0;
            dma_direction_reg     <= '0;
            area_top_left_reg     <= '0;
            area_bottom_right_reg <= '0;
            drawing_offset_reg    <= '0;
            display_start_reg     <= '0;
            horizontal_range_reg  <= '0;
            vertical_range_reg    <= '0;
            readback_latch_reg    <= '0;
        end
        else if (stg_advance)
        begin
            draw_mode_bits_reg    <= draw_mode_bits_next;
            mask_bits_reg         <= mask_bits_next;
            display_mode_bits_reg <= display_mode_bits_next;
            display_disabled_reg  <= display_disabled_next;
            interlace_field_reg   <= interlace_field_next;
            irq_flag_reg          <= irq_flag_next;
            dma_direction_reg     <= dma_direction_next;
            area_top_left_reg     <= area_top_left_next;
            area_bottom_right_reg <= area_bottom_right_next;
            drawing_offset_reg    <= drawing_offset_next;
            display_start_reg     <= display_start_next;
            horizontal_range_reg  <= horizontal_range_next;
            vertical_range_reg    <= vertical_range_next;
            readback_latch_reg    <= readback_latch_next;
        end
    end

    // Load the result register on a read, drop it once transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_advance && stg_is_read)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_advance && stg_is_read)
        begin
            read_data_reg <= read_data_next;
        end
    end

endmodule

// File: hdl/gscr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gscr_checker
// Port-level checks for the GPU status/control block, bound to the top level.
// ----------------------------------------------------------------------------
module gscr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  cmd,
    input logic [31:0] write_data,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] read_data
);

    // Hold an offered access until its transfer
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(cmd) && $stable(write_data))
        else $error("offered access changed or dropped before transfer");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data))
        else $error("stalled result changed or dropped");

    // Never stall the input while the result side can drain
    a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("input held off with result side free");

    // A status word has fixed ones at 26..28, a latch value has zeros there
    a_word_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !read_data[31] && !read_data[25] &&
            (read_data[28:26] == 3'b111 || read_data[28:26] == 3'b000))
        else $error("result word has impossible fixed bits");

    // A latch read result carries no status-only bits
    a_latch_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_data[28:26] == 3'b000 |-> read_data[31:22] == 10'd0)
        else $error("latch value wider than any loaded source");

endmodule

bind gpu_status_control_registers_unit gscr_checker u_gscr_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .write_data (write_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .read_data  (read_data)
);
